// ===== design/epoch_seconds_to_calendar_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the epoch seconds to calendar unit
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_UNIT_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_UNIT_ASSERT_SVH

// Same-cycle implication
`define ESC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ESC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, codes and constant tables of the epoch seconds to calendar
// unit.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

  // Field widths
  localparam int unsigned SecondsW = 32;
  localparam int unsigned YearW    = 12;
  localparam int unsigned DaysW    = 16;   // day count fits below 2^16
  localparam int unsigned RemW     = 7;    // largest divisor is 100
  localparam int unsigned CntW     = 2;

  // Divider pass: multiply step, then remainder step, then hand-off
  localparam logic [CntW-1:0] DivSteps = 2'd2;

  // Register index decoded from paddr[2]
  localparam logic REG_BASE_YEAR = 1'b0;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_e;

  // Divider passes: seconds, minutes, hours, then base year by 100
  typedef enum logic [1:0] {
    PH_SEC,
    PH_MIN,
    PH_HOUR,
    PH_CENT
  } phase_e;

  typedef struct packed {
    logic   div_load;
    phase_e div_sel;
    logic   div_mul;
    logic   div_rem;
    logic   year_init;
    logic   year_step;
    logic   month_init;
    logic   month_step;
    logic   out_load;
  } esc_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
    logic out_hold;
  } esc_status_t;

  // Reciprocal of each divisor, exact for any 32-bit dividend; the
  // quotient is the product shifted right by 37 (by 36 for the hour pass)
  function automatic logic [SecondsW-1:0] div_magic(input phase_e ph);
    logic [SecondsW-1:0] m;
    unique case (ph) inside
      PH_SEC, PH_MIN: m = 32'h8888_8889;
      PH_HOUR:        m = 32'hAAAA_AAAB;
      PH_CENT:        m = 32'h51EB_851F;
      default:        m = 32'h8888_8889;
    endcase
    return m;
  endfunction

  function automatic logic [RemW-1:0] div_divisor(input phase_e ph);
    logic [RemW-1:0] d;
    unique case (ph) inside
      PH_SEC, PH_MIN: d = 7'd60;
      PH_HOUR:        d = 7'd24;
      PH_CENT:        d = 7'd100;
      default:        d = 7'd60;
    endcase
    return d;
  endfunction

  function automatic phase_e next_phase(input phase_e ph);
    phase_e n;
    unique case (ph)
      PH_SEC:  n = PH_MIN;
      PH_MIN:  n = PH_HOUR;
      PH_HOUR: n = PH_CENT;
      PH_CENT: n = PH_CENT;
      default: n = PH_SEC;
    endcase
    return n;
  endfunction

  // Month lengths of a common year
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] d;
    case (m) inside
      4'd2:                      d = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== design/esc_datapath.sv =====
// ----------------------------------------------------------------------------
// esc_datapath
// Shared reciprocal divider, year and month subtraction loops and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_datapath
  import esc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire esc_cmd_t             cmd_i,
  output esc_status_t               status_o,
  input  wire logic [SecondsW-1:0]  seconds_since_epoch_i,
  input  wire logic [YearW-1:0]     base_year_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [11:0]               year_o,
  output logic [3:0]                month_o,
  output logic [4:0]                day_of_month_o,
  output logic [4:0]                hour_o,
  output logic [5:0]                minute_o,
  output logic [5:0]                second_o
);

  logic [SecondsW-1:0] num_q, num_d;
  logic [SecondsW-1:0] quo_q, quo_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [5:0]          sec_q, sec_d;
  logic [5:0]          min_q, min_d;
  logic [4:0]          hour_q, hour_d;
  logic [DaysW-1:0]    days_q, days_d;
  logic [YearW:0]      year_q, year_d;
  logic [RemW-1:0]     ymod_q, ymod_d;
  logic [1:0]          cent_q, cent_d;
  logic [3:0]          month_q, month_d;
  logic                out_valid_q, out_valid_d;

  logic [63:0]         prod;
  logic [SecondsW-1:0] quo_mul;
  logic [2*RemW-1:0]   qd_lo;
  logic [RemW-1:0]     rem_calc;
  logic [SecondsW-1:0] load_val;
  logic                leap;
  logic [8:0]          ylen;
  logic [4:0]          mlen;
  logic                year_done;
  logic                month_done;

  // Quotient by reciprocal multiplication of the held dividend
  assign prod    = {32'd0, num_q} * {32'd0, div_magic(cmd_i.div_sel)};
  assign quo_mul = (cmd_i.div_sel == PH_HOUR) ? {4'd0, prod[63:36]} : {5'd0, prod[63:37]};

  // Remainder fits in seven bits, so only the low bits of quotient times divisor count
  assign qd_lo    = {{RemW{1'b0}}, quo_q[RemW-1:0]} *
                    {{RemW{1'b0}}, div_divisor(cmd_i.div_sel)};
  assign rem_calc = num_q[RemW-1:0] - qd_lo[RemW-1:0];

  // Dividend of each pass: the input, the last quotient, or the base year
  always_comb begin
    case (cmd_i.div_sel) inside
      PH_SEC:          load_val = seconds_since_epoch_i;
      PH_MIN, PH_HOUR: load_val = quo_q;
      PH_CENT:         load_val = {{(SecondsW-YearW){1'b0}}, base_year_i};
      default:         load_val = seconds_since_epoch_i;
    endcase
  end

  // Leap rule from the low year bits, year mod 100 and century mod 4
  assign leap = ((year_q[1:0] == 2'd0) && (ymod_q != 7'd0)) ||
                ((ymod_q == 7'd0) && (cent_q == 2'd0));
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_len(month_q) + {4'd0, (month_q == 4'd2) && leap};

  assign year_done  = (days_q < {7'd0, ylen});
  assign month_done = (month_q == 4'd12) || (days_q < {11'd0, mlen});

  always_comb begin
    num_d   = num_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    sec_d   = sec_q;
    min_d   = min_q;
    hour_d  = hour_q;
    days_d  = days_q;
    year_d  = year_q;
    ymod_d  = ymod_q;
    cent_d  = cent_q;
    month_d = month_q;

    // Start a division pass and keep the remainder of the last one
    if (cmd_i.div_load) begin
      num_d = load_val;
      case (cmd_i.div_sel)
        PH_MIN:  sec_d = rem_q[5:0];
        PH_HOUR: min_d = rem_q[5:0];
        PH_CENT: begin
          hour_d = rem_q[4:0];
          days_d = quo_q[DaysW-1:0];
        end
        default: ;
      endcase
    end else if (cmd_i.div_mul) begin
      quo_d = quo_mul;
    end else if (cmd_i.div_rem) begin
      rem_d = rem_calc;
    end

    // Year loop: take away whole years
    if (cmd_i.year_init) begin
      year_d = {1'b0, base_year_i};
      ymod_d = rem_q;
      cent_d = quo_q[1:0];
    end else if (cmd_i.year_step && !year_done) begin
      days_d = days_q - {7'd0, ylen};
      year_d = year_q + 13'd1;
      if (ymod_q == 7'd99) begin
        ymod_d = '0;
        cent_d = cent_q + 2'd1;
      end else begin
        ymod_d = ymod_q + 7'd1;
      end
    end

    // Month loop: take away month lengths
    if (cmd_i.month_init) begin
      month_d = 4'd1;
    end else if (cmd_i.month_step && !month_done) begin
      days_d  = days_q - {11'd0, mlen};
      month_d = month_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    sec_q   <= sec_d;
    min_q   <= min_d;
    hour_q  <= hour_d;
    days_q  <= days_d;
    year_q  <= year_d;
    ymod_q  <= ymod_d;
    cent_q  <= cent_d;
    month_q <= month_d;
  end

  // Result register: load on command, drop valid once the transfer completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      year_o         <= year_q[YearW-1:0];
      month_o        <= month_q;
      day_of_month_o <= days_q[4:0] + 5'd1;
      hour_o         <= hour_q;
      minute_o       <= min_q;
      second_o       <= sec_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o.year_done  = year_done;
  assign status_o.month_done = month_done;
  assign status_o.out_hold   = out_valid_q && out_stall_i;

endmodule

`default_nettype wire

// ===== design/esc_ctrl.sv =====
// ----------------------------------------------------------------------------
// esc_ctrl
// Sequencer: runs the four divider passes, the year loop, the month loop
// and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "epoch_seconds_to_calendar_unit_assert.svh"

module esc_ctrl
  import esc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire esc_status_t status_i,
  output esc_cmd_t         cmd_o
);

  state_e          state_q, state_d;
  phase_e          phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Next state
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DIV;
          phase_d = PH_SEC;
          cnt_d   = DivSteps;
        end
      end
      ST_DIV: begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - 2'd1;
        end else if (phase_q == PH_CENT) begin
          state_d = ST_YEAR;
        end else begin
          phase_d = next_phase(phase_q);
          cnt_d   = DivSteps;
        end
      end
      ST_YEAR: begin
        if (status_i.year_done) begin
          state_d = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (status_i.month_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status_i.out_hold) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o = '0;
    cmd_o.div_sel = PH_SEC;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.div_load = in_valid_i;
      end
      ST_DIV: begin
        if (cnt_q == DivSteps) begin
          cmd_o.div_mul = 1'b1;
          cmd_o.div_sel = phase_q;
        end else if (cnt_q != '0) begin
          cmd_o.div_rem = 1'b1;
          cmd_o.div_sel = phase_q;
        end else if (phase_q == PH_CENT) begin
          cmd_o.year_init = 1'b1;
        end else begin
          cmd_o.div_load = 1'b1;
          cmd_o.div_sel  = next_phase(phase_q);
        end
      end
      ST_YEAR: begin
        cmd_o.year_step  = 1'b1;
        cmd_o.month_init = status_i.year_done;
      end
      ST_MONTH: begin
        cmd_o.month_step = 1'b1;
      end
      ST_DONE: begin
        cmd_o.out_load = !status_i.out_hold;
      end
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_SEC;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  `ESC_ASSERT_NEXT(a_accept_starts_div,
                   in_valid_i && (state_q == ST_IDLE),
                   state_q == ST_DIV,
                   "accepted item did not start the divider")
  `ESC_ASSERT_NEXT(a_year_to_month,
                   (state_q == ST_YEAR) && status_i.year_done,
                   state_q == ST_MONTH,
                   "year loop end did not start the month loop")
  `ESC_ASSERT_NEXT(a_month_holds,
                   (state_q == ST_MONTH) && !status_i.month_done,
                   state_q == ST_MONTH,
                   "month loop left early")
  `ESC_ASSERT_NEXT(a_result_waits,
                   (state_q == ST_DONE) && status_i.out_hold,
                   state_q == ST_DONE,
                   "result dropped while output register held")

endmodule

`default_nettype wire

// ===== design/epoch_seconds_to_calendar_unit.sv =====
// Sequence from accept to result valid: reciprocal division (multiply, remainder,
// hand-off for each of four passes), the year loop (up to 136 years), the month
// loop (up to 11 months), then the result load, which waits while the output is held.
// Flow: one item at a time; the next transfer is taken the cycle after the result is loaded.
// Reset: asynchronous, active low; the base year resets to 2000, no result valid.
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit
// Converts seconds since 1 January of a configurable epoch year into a
// Gregorian date and time of day.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_calendar_unit
  import esc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // APB-style configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  // Input channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [SecondsW-1:0] seconds_since_epoch_i,
  // Output channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [11:0]              year_o,
  output logic [3:0]               month_o,
  output logic [4:0]               day_of_month_o,
  output logic [4:0]               hour_o,
  output logic [5:0]               minute_o,
  output logic [5:0]               second_o
);

  logic [YearW-1:0] base_year_q, base_year_d;
  logic             cfg_write;
  esc_cmd_t         cmd;
  esc_status_t      status;

  // Configuration register; writes to other addresses are dropped
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_comb begin
    base_year_d = base_year_q;
    if (cfg_write && (paddr[2] == REG_BASE_YEAR)) begin
      base_year_d = pwdata[YearW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_year_q <= 12'd2000;
    end else begin
      base_year_q <= base_year_d;
    end
  end

  assign prdata = (paddr[2] == REG_BASE_YEAR) ? {20'd0, base_year_q} : 32'd0;

  esc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  esc_datapath u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .status_o              (status),
    .seconds_since_epoch_i (seconds_since_epoch_i),
    .base_year_i           (base_year_q),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .year_o                (year_o),
    .month_o               (month_o),
    .day_of_month_o        (day_of_month_o),
    .hour_o                (hour_o),
    .minute_o              (minute_o),
    .second_o              (second_o)
  );

endmodule

`default_nettype wire

// ===== test/tb_epoch_seconds_to_calendar_unit.sv =====
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar_unit
// Self-checking bench for the epoch seconds to calendar converter. Drives
// second counts under several epoch years, including out-of-range and
// wrapping ones, predicts each calendar date in the bench and compares every
// output transfer field by field. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------

module tb_epoch_seconds_to_calendar_unit;
  import esc_pkg::*;

  localparam logic [2:0] BaseYearAddr  = {REG_BASE_YEAR, 2'b00};
  localparam logic [2:0] SpareRegAddr  = {~REG_BASE_YEAR, 2'b00};
  localparam int unsigned SecsPerDay   = 86400;
  localparam int unsigned LastSecOfDay = SecsPerDay - 1;
  localparam int unsigned IdleLimit    = 5000;
  localparam int unsigned PrintLimit   = 200;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_t;

  typedef struct packed {
    logic [SecondsW-1:0] secs;
    calendar_t           date;
  } pending_date_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_HEAVY,
    STALL_WAVE
  } stall_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [SecondsW-1:0] seconds_since_epoch_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [11:0]         year_o;
  logic [3:0]          month_o;
  logic [4:0]          day_of_month_o;
  logic [4:0]          hour_o;
  logic [5:0]          minute_o;
  logic [5:0]          second_o;

  pending_date_t pending_dates[$];
  logic [11:0]   epoch_model;
  int unsigned   mismatches;
  int unsigned   burst_left;
  int unsigned   idle_cycles;
  int unsigned   stall_run;
  stall_mode_e   stall_mode;

  epoch_seconds_to_calendar_unit uut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .seconds_since_epoch_i (seconds_since_epoch_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .year_o                (year_o),
    .month_o               (month_o),
    .day_of_month_o        (day_of_month_o),
    .hour_o                (hour_o),
    .minute_o              (minute_o),
    .second_o              (second_o)
  );

  // Generate the clock
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Calendar arithmetic
  // ---------------------------------------------------------------------------

  function automatic bit is_leap_year(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int unsigned year_length(input int unsigned yr);
    return is_leap_year(yr) ? 366 : 365;
  endfunction

  function automatic int unsigned month_length(input int unsigned yr,
                                               input int unsigned mon);
    int unsigned len;
    case (mon)
      2:          len = is_leap_year(yr) ? 29 : 28;
      4, 6, 9, 11: len = 30;
      default:    len = 31;
    endcase
    return len;
  endfunction

  // Convert a second count to a date; the year is kept wide for leap decisions
  function automatic calendar_t calendar_of(input logic [SecondsW-1:0] secs,
                                            input logic [11:0] epoch);
    calendar_t   c;
    int unsigned rest;
    int unsigned days;
    int unsigned yr;
    int unsigned mon;
    rest     = secs;
    c.second = 6'(rest % 60);
    rest     = rest / 60;
    c.minute = 6'(rest % 60);
    rest     = rest / 60;
    c.hour   = 5'(rest % 24);
    days     = rest / 24;
    yr       = 32'(epoch);
    while (days >= year_length(yr)) begin
      days = days - year_length(yr);
      yr++;
    end
    mon = 1;
    while (mon < 12 && days >= month_length(yr, mon)) begin
      days = days - month_length(yr, mon);
      mon++;
    end
    c.year  = 12'(yr);
    c.month = 4'(mon);
    c.day   = 5'(days + 1);
    return c;
  endfunction

  // Seconds from the epoch to a given date, yrs years after the epoch year
  function automatic longint seconds_of_date(input int unsigned epoch,
                                             input int unsigned yrs,
                                             input int unsigned mon,
                                             input int unsigned dom,
                                             input int unsigned sod);
    longint days;
    days = 0;
    for (int unsigned y = epoch; y < epoch + yrs; y++) days += year_length(y);
    for (int unsigned m = 1; m < mon; m++) days += month_length(epoch + yrs, m);
    days += dom - 1;
    return days * SecsPerDay + sod;
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want,
                                 input logic [SecondsW-1:0] secs);
    mismatches++;
    if (mismatches <= PrintLimit)
      $display("mismatch %0t: %s got %0d expected %0d (seconds %0d)",
               $realtime, what, got, want, secs);
  endtask

  // Compare each output transfer against the oldest pending date
  always @(posedge clk_i) begin
    pending_date_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("result with nothing pending", 0, 0, '0);
      end else begin
        want = pending_dates.pop_front();
        if (year_o !== want.date.year)
          report_mismatch("year", int'(year_o), int'(want.date.year), want.secs);
        if (month_o !== want.date.month)
          report_mismatch("month", int'(month_o), int'(want.date.month), want.secs);
        if (day_of_month_o !== want.date.day)
          report_mismatch("day_of_month", int'(day_of_month_o), int'(want.date.day),
                          want.secs);
        if (hour_o !== want.date.hour)
          report_mismatch("hour", int'(hour_o), int'(want.date.hour), want.secs);
        if (minute_o !== want.date.minute)
          report_mismatch("minute", int'(minute_o), int'(want.date.minute), want.secs);
        if (second_o !== want.date.second)
          report_mismatch("second", int'(second_o), int'(want.date.second), want.secs);
      end
    end
  end

  // End the run when no transfer of any kind happens for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (psel && penable)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("tb_epoch_seconds_to_calendar_unit: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stall the output on a pattern that switches mode every so often
  always @(negedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_run  = $urandom_range(1, 200);
    end
    stall_run--;
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_COIN:  out_stall_i <= ($urandom_range(0, 1) == 1);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 7) != 0);
      default:     out_stall_i <= ((stall_run % 16) < 8);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (addr == BaseYearAddr) epoch_model = data[11:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Read the epoch register back and compare with the bench copy
  task automatic check_epoch_readback();
    logic [31:0] value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= BaseYearAddr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    value = prdata;
    if (value[11:0] !== epoch_model)
      report_mismatch("base year readback", int'(value[11:0]), int'(epoch_model), '0);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Send one second count; bursts of random length with random gaps
  task automatic send_seconds(input logic [SecondsW-1:0] secs);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i            <= 1'b1;
    seconds_since_epoch_i <= secs;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_dates.push_back('{secs: secs, date: calendar_of(secs, epoch_model)});
    burst_left--;
    @(negedge clk_i);
  endtask

  // Hold the sender off until every pending date has come back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_dates.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_epoch(input logic [11:0] epoch);
    wait_for_results();
    apb_write(BaseYearAddr, {20'(~20'd0 & $urandom), epoch});
    check_epoch_readback();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset epoch and the two ends of the second count
  task automatic test_reset_state();
    check_epoch_readback();
    send_seconds('0);
    send_seconds('1);
  endtask

  // Writes to the unused index are dropped; upper data bits are dropped
  task automatic test_register_map();
    wait_for_results();
    apb_write(BaseYearAddr, 32'hFFFF_F7B2);
    check_epoch_readback();
    apb_write(SpareRegAddr, 32'd1234);
    check_epoch_readback();
    send_seconds(32'd86400);
  endtask

  // Rollover of second, minute, hour and day
  task automatic test_time_of_day();
    set_epoch(12'd1970);
    send_seconds(32'd59);
    send_seconds(32'd60);
    send_seconds(32'd3599);
    send_seconds(32'd3600);
    send_seconds(LastSecOfDay);
    send_seconds(32'(seconds_of_date(1970, 0, 12, 31, LastSecOfDay)));
  endtask

  // Leap day, leap-year end, and the common century year
  task automatic test_leap_rules();
    set_epoch(12'd2000);
    send_seconds(32'(seconds_of_date(2000, 0, 2, 29, 0)));
    send_seconds(32'(seconds_of_date(2000, 0, 12, 31, LastSecOfDay)));
    send_seconds(32'(seconds_of_date(2000, 1, 1, 1, 0)));
    send_seconds(32'(seconds_of_date(2000, 100, 2, 28, LastSecOfDay)));
    send_seconds(32'(seconds_of_date(2000, 100, 3, 1, 0)));
    set_epoch(12'd2100);
    send_seconds(32'(seconds_of_date(2100, 0, 3, 1, 0) - 1));
  endtask

  // Year zero counts as leap; years past 4095 wrap but keep the leap rule
  task automatic test_year_extremes();
    set_epoch(12'd0);
    send_seconds(32'(seconds_of_date(0, 0, 2, 29, 43200)));
    send_seconds('1);
    set_epoch(12'd4095);
    send_seconds(32'(seconds_of_date(4095, 1, 1, 1, 0) - 1));
    send_seconds(32'(seconds_of_date(4095, 1, 2, 29, 0)));
    send_seconds('1);
  endtask

  // Random second counts: some raw, some in the first four years, some built from valid dates near day boundaries
  task automatic test_random_dates(input logic [11:0] epoch, input int unsigned count);
    longint      secs;
    int unsigned yrs;
    int unsigned mon;
    int unsigned sod;
    set_epoch(epoch);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2) wait_for_results();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: secs = longint'($urandom);
        4, 5:       secs = longint'($urandom_range(0, SecsPerDay * 366 * 4));
        default: begin
          yrs = $urandom_range(0, 135);
          mon = $urandom_range(1, 12);
          case ($urandom_range(0, 2))
            0:       sod = 0;
            1:       sod = LastSecOfDay;
            default: sod = $urandom_range(0, LastSecOfDay);
          endcase
          secs = seconds_of_date(32'(epoch), yrs, mon,
                                 $urandom_range(1, month_length(epoch + yrs, mon)), sod);
          if ($urandom_range(0, 3) == 0) secs = secs - 1;
        end
      endcase
      if (secs < 0 || secs > 64'hFFFF_FFFF) secs = longint'($urandom);
      send_seconds(32'(secs));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni                = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    in_valid_i            = 1'b0;
    seconds_since_epoch_i = '0;
    out_stall_i           = 1'b0;
    epoch_model           = 12'd2000;
    mismatches            = 0;
    burst_left            = 0;
    idle_cycles           = 0;
    stall_run             = 0;
    stall_mode            = STALL_NONE;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_register_map();
    test_time_of_day();
    test_leap_rules();
    test_year_extremes();
    test_random_dates(12'd1970, 150);
    test_random_dates(12'd2100, 150);
    test_random_dates(12'($urandom_range(1971, 2099)), 150);
    test_random_dates(12'd0, 100);
    test_random_dates(12'd4095, 100);
    test_random_dates(12'($urandom), 100);

    // Drain, then allow for a stray late result
    wait_for_results();
    repeat (300) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_epoch_seconds_to_calendar_unit: PASS");
    end else begin
      $display("tb_epoch_seconds_to_calendar_unit: FAIL");
    end
    $finish;
  end

endmodule
